// ===== rtl/lalign_pkg.sv =====
package lalign_pkg;

  localparam int READING_BITS_DEF = 12;
  localparam int SPEED_BITS_DEF   = 12;

  localparam int CFG_READ_W  = 12;
  localparam int CFG_SPEED_W = 11;
  localparam int CFG_COUNT_W = 8;
  localparam int CFG_TIME_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int DRIVE_W  = 16;
  localparam int STATUS_W = 2;
  localparam int M_DATA_W = 40;

  // max_speed / 100 as (max_speed * STEP_RECIP) >> STEP_SHIFT, exact below 2048
  localparam int STEP_RECIP = 5243;
  localparam int STEP_SHIFT = 19;
  localparam int STEP_W     = 5;

  localparam logic [CFG_COUNT_W-1:0] HIT_MAX     = '1;
  localparam logic [CFG_TIME_W-1:0]  ELAPSED_MAX = '1;

  localparam logic [CFG_READ_W-1:0]  RST_FULL_DRIVE    = 12'd100;
  localparam logic [CFG_READ_W-1:0]  RST_REVERSE_DRIVE = 12'd4000;
  localparam logic [CFG_SPEED_W-1:0] RST_MIN_SPEED     = 11'd150;
  localparam logic [CFG_SPEED_W-1:0] RST_MAX_SPEED     = 11'd1500;
  localparam logic [CFG_COUNT_W-1:0] RST_PRECISION     = 8'd25;
  localparam logic [CFG_TIME_W-1:0]  RST_TIMEOUT       = 16'd3000;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_DONE = 2'd2,
    ST_FAIL = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FULL_DRIVE    = 3'd0,
    CFG_REVERSE_DRIVE = 3'd1,
    CFG_MIN_SPEED     = 3'd2,
    CFG_MAX_SPEED     = 3'd3,
    CFG_PRECISION     = 3'd4,
    CFG_TIMEOUT       = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_APPLY
  } top_state_t;

  typedef enum logic [1:0] {
    L_IDLE,
    L_MUL,
    L_DIV,
    L_FIN
  } lane_state_t;

  typedef struct packed {
    logic [CFG_READ_W-1:0]  full_drive;
    logic [CFG_READ_W-1:0]  reverse_drive;
    logic [CFG_SPEED_W-1:0] min_speed;
    logic [CFG_SPEED_W-1:0] max_speed;
    logic [CFG_COUNT_W-1:0] precision_count;
    logic [CFG_TIME_W-1:0]  timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic  apply;
    kind_t kind;
    logic  direction;
  } merge_ctl_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    status_t                   status;
  } result_t;

endpackage

// ===== rtl/line_alignment_drive_controller.sv =====
// Channel  Direction  Handshake                Payload
// s_*      in         s_tvalid / s_tready      tuser kind; tdata direction, readings
// m_*      out        m_tvalid / m_tready      tdata left/right drive, status
// cfg_*    in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A sample beat on an active run goes through the bit-serial divider in each side lane
// before its result is applied; start, tick, ignored and inactive-sample beats skip the
// lanes and are applied straight from the idle state.
// One beat is in flight at a time; the next is taken while the last result waits on m_*.
// rst is synchronous and active high; it restores the register defaults and an idle run.
// A stalled m_tready holds the result and holds the block in its final step until taken.
module line_alignment_drive_controller #(
  parameter int READING_BITS = lalign_pkg::READING_BITS_DEF,
  parameter int SPEED_BITS   = lalign_pkg::SPEED_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // direction, left_reading, right_reading (from bit 0 up)
  input  logic [((1 + 2*READING_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // kind
  input  logic [1:0]                           s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // left_drive, right_drive, status (from bit 0 up)
  output logic [lalign_pkg::M_DATA_W-1:0]      m_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lalign_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lalign_pkg::CFG_DATA_W-1:0]    cfg_data
);

  lalign_pkg::top_state_t state, state_next;
  lalign_pkg::cfg_t       cfg;
  lalign_pkg::kind_t      kind_q;
  logic                   dir_q;
  lalign_pkg::merge_ctl_t ctl;
  lalign_pkg::result_t    result;
  lalign_pkg::status_t    run_status;

  logic signed [SPEED_BITS-1:0]             left_speed, right_speed;
  logic signed [lalign_pkg::DRIVE_W-1:0]    left_drive, right_drive;
  logic                                     left_busy, right_busy;
  logic                                     in_accept, lane_start, out_free;

  assign cfg_ready = 1'b1;
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // Register writes; unlisted indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_drive      <= lalign_pkg::RST_FULL_DRIVE;
      cfg.reverse_drive   <= lalign_pkg::RST_REVERSE_DRIVE;
      cfg.min_speed       <= lalign_pkg::RST_MIN_SPEED;
      cfg.max_speed       <= lalign_pkg::RST_MAX_SPEED;
      cfg.precision_count <= lalign_pkg::RST_PRECISION;
      cfg.timeout_ms      <= lalign_pkg::RST_TIMEOUT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lalign_pkg::CFG_FULL_DRIVE:    cfg.full_drive      <= cfg_data[lalign_pkg::CFG_READ_W-1:0];
        lalign_pkg::CFG_REVERSE_DRIVE: cfg.reverse_drive   <= cfg_data[lalign_pkg::CFG_READ_W-1:0];
        lalign_pkg::CFG_MIN_SPEED:     cfg.min_speed       <= cfg_data[lalign_pkg::CFG_SPEED_W-1:0];
        lalign_pkg::CFG_MAX_SPEED:     cfg.max_speed       <= cfg_data[lalign_pkg::CFG_SPEED_W-1:0];
        lalign_pkg::CFG_PRECISION:     cfg.precision_count <= cfg_data[lalign_pkg::CFG_COUNT_W-1:0];
        lalign_pkg::CFG_TIMEOUT:       cfg.timeout_ms      <= cfg_data[lalign_pkg::CFG_TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state: only a sample on an active run goes through the lanes
  always_comb begin
    state_next = state;
    unique case (state)
      lalign_pkg::S_IDLE: begin
        if (in_accept) state_next = lane_start ? lalign_pkg::S_CALC : lalign_pkg::S_APPLY;
      end
      lalign_pkg::S_CALC: begin
        if (!left_busy && !right_busy) state_next = lalign_pkg::S_APPLY;
      end
      lalign_pkg::S_APPLY: begin
        if (out_free) state_next = lalign_pkg::S_IDLE;
      end
      default: state_next = lalign_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = (state == lalign_pkg::S_IDLE);
    lane_start    = s_tvalid && (state == lalign_pkg::S_IDLE) &&
                    (lalign_pkg::kind_t'(s_tuser) == lalign_pkg::KIND_SAMPLE) &&
                    (run_status == lalign_pkg::ST_RUN);
    ctl.apply     = (state == lalign_pkg::S_APPLY) && out_free;
    ctl.kind      = kind_q;
    ctl.direction = dir_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lalign_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the accepted beat's kind and direction until it is applied
  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_q <= lalign_pkg::kind_t'(s_tuser);
      dir_q  <= s_tdata[0];
    end
  end

  lalign_lane #(
    .READING_BITS (READING_BITS),
    .SPEED_BITS   (SPEED_BITS)
  ) u_lane_left (
    .clk     (clk),
    .rst     (rst),
    .start   (lane_start),
    .reading (s_tdata[READING_BITS:1]),
    .speed   (left_speed),
    .cfg     (cfg),
    .busy    (left_busy),
    .drive   (left_drive)
  );

  lalign_lane #(
    .READING_BITS (READING_BITS),
    .SPEED_BITS   (SPEED_BITS)
  ) u_lane_right (
    .clk     (clk),
    .rst     (rst),
    .start   (lane_start),
    .reading (s_tdata[2*READING_BITS:READING_BITS+1]),
    .speed   (right_speed),
    .cfg     (cfg),
    .busy    (right_busy),
    .drive   (right_drive)
  );

  lalign_merge #(
    .SPEED_BITS (SPEED_BITS)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .cfg         (cfg),
    .left_drive  (left_drive),
    .right_drive (right_drive),
    .left_speed  (left_speed),
    .right_speed (right_speed),
    .run_status  (run_status),
    .result      (result)
  );

  // Output register parts the result from the next beat's work
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.apply) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      m_tdata <= lalign_pkg::M_DATA_W'({result.status, result.right_drive, result.left_drive});
    end
  end

endmodule

// ===== rtl/lalign_lane.sv =====
module lalign_lane #(
  parameter int READING_BITS = lalign_pkg::READING_BITS_DEF,
  parameter int SPEED_BITS   = lalign_pkg::SPEED_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [READING_BITS-1:0]             reading,
  input  logic signed [SPEED_BITS-1:0]        speed,
  input  lalign_pkg::cfg_t                    cfg,
  output logic                                busy,
  output logic signed [lalign_pkg::DRIVE_W-1:0] drive
);

  localparam int RX    = (READING_BITS > lalign_pkg::CFG_READ_W) ?
                         READING_BITS : lalign_pkg::CFG_READ_W;
  localparam int DM_W  = lalign_pkg::CFG_READ_W;
  localparam int PM_W  = RX + SPEED_BITS + 1;
  localparam int VW    = PM_W + 2;
  localparam int CNT_W = $clog2(PM_W);

  lalign_pkg::lane_state_t state, state_next;

  logic [RX-1:0]                a_mag;
  logic [SPEED_BITS-1:0]        b_mag;
  logic [DM_W-1:0]              dmag;
  logic                         dzero;
  logic                         neg;
  logic signed [SPEED_BITS-1:0] speed_q;
  logic [PM_W-1:0]              quot;
  logic [DM_W-1:0]              rem;
  logic [CNT_W-1:0]             cnt;

  logic signed [RX:0]           diff;
  logic signed [DM_W:0]         den;
  logic [DM_W:0]                rem_sh;
  logic signed [PM_W:0]         q_signed;
  logic signed [VW-1:0]         v;
  logic signed [lalign_pkg::DRIVE_W-1:0] v_sat;

  assign diff = $signed({1'b0, RX'(reading)}) - $signed({1'b0, RX'(cfg.full_drive)});
  assign den  = $signed({1'b0, cfg.reverse_drive}) - $signed({1'b0, cfg.full_drive});
  assign rem_sh = {rem, quot[PM_W-1]};

  assign q_signed = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign v = VW'(q_signed) + VW'(speed_q);

  always_comb begin
    if (dzero) begin
      v_sat = '0;
    end else if (v > VW'(32767)) begin
      v_sat = 16'sh7FFF;
    end else if (v < -VW'(32768)) begin
      v_sat = 16'sh8000;
    end else begin
      v_sat = lalign_pkg::DRIVE_W'(v);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lalign_pkg::L_IDLE: if (start) state_next = lalign_pkg::L_MUL;
      lalign_pkg::L_MUL:  state_next = dzero ? lalign_pkg::L_FIN : lalign_pkg::L_DIV;
      lalign_pkg::L_DIV:  if (cnt == CNT_W'(PM_W - 1)) state_next = lalign_pkg::L_FIN;
      lalign_pkg::L_FIN:  state_next = lalign_pkg::L_IDLE;
      default:            state_next = lalign_pkg::L_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != lalign_pkg::L_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lalign_pkg::L_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sign and magnitude split so the divider works on unsigned values
  always_ff @(posedge clk) begin
    case (state)
      lalign_pkg::L_IDLE: begin
        if (start) begin
          a_mag   <= RX'(diff < 0 ? -diff : diff);
          b_mag   <= SPEED_BITS'(speed < 0 ? -speed : speed);
          dmag    <= DM_W'(den < 0 ? -den : den);
          dzero   <= (den == 0);
          neg     <= (diff < 0) ^ (speed > 0) ^ (den < 0);
          speed_q <= speed;
        end
      end
      lalign_pkg::L_MUL: begin
        quot <= {(PM_W - 1)'((PM_W - 1)'(a_mag) * (PM_W - 1)'(b_mag)), 1'b0};
        rem  <= '0;
        cnt  <= '0;
      end
      lalign_pkg::L_DIV: begin
        if (rem_sh >= {1'b0, dmag}) begin
          rem  <= DM_W'(rem_sh - {1'b0, dmag});
          quot <= {quot[PM_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[DM_W-1:0];
          quot <= {quot[PM_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
      end
      lalign_pkg::L_FIN: begin
        drive <= v_sat;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/lalign_merge.sv =====
module lalign_merge #(
  parameter int SPEED_BITS = lalign_pkg::SPEED_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lalign_pkg::merge_ctl_t                ctl,
  input  lalign_pkg::cfg_t                      cfg,
  input  logic signed [lalign_pkg::DRIVE_W-1:0] left_drive,
  input  logic signed [lalign_pkg::DRIVE_W-1:0] right_drive,
  output logic signed [SPEED_BITS-1:0]          left_speed,
  output logic signed [SPEED_BITS-1:0]          right_speed,
  output lalign_pkg::status_t                   run_status,
  output lalign_pkg::result_t                   result
);

  localparam int EW = ((SPEED_BITS > 12) ? SPEED_BITS : 12) + 2;
  localparam int MW = (EW > 18) ? EW : 18;
  localparam int DW = lalign_pkg::DRIVE_W + 1;

  logic left_seen, right_seen, forward_mode;
  logic [lalign_pkg::CFG_COUNT_W-1:0] settled_hits;
  logic [lalign_pkg::CFG_TIME_W-1:0]  elapsed_ms;
  logic [lalign_pkg::STEP_W-1:0]      step;

  logic signed [SPEED_BITS-1:0]       left_speed_next, right_speed_next;
  logic                               left_seen_next, right_seen_next, forward_mode_next;
  logic [lalign_pkg::CFG_COUNT_W-1:0] settled_hits_next;
  logic [lalign_pkg::CFG_TIME_W-1:0]  elapsed_ms_next;
  lalign_pkg::status_t                run_status_next;

  logic signed [EW-1:0] ls_x, rs_x, mn_x, max_x, step_x, ls_slow, rs_slow;
  logic signed [DW-1:0] ld_x, rd_x;
  logic [DW-1:0]        ld_mag, rd_mag;
  logic                 ls_seen_n, rs_seen_n, hit;

  function automatic logic [EW-1:0] absx(input logic signed [EW-1:0] val);
    return (val < 0) ? -val : val;
  endfunction

  function automatic logic signed [EW-1:0] slow_side(
    input logic signed [EW-1:0] spd,
    input logic                 seen,
    input logic                 fwd,
    input logic signed [EW-1:0] mn,
    input logic signed [EW-1:0] stp
  );
    logic signed [EW-1:0] s;
    s = spd;
    if (fwd) begin
      if (seen && s > mn) s = s - stp;
      if (s < mn) s = mn;
    end else begin
      if (seen && s < -mn) s = s + stp;
      if (s > -mn) s = -mn;
    end
    return s;
  endfunction

  assign ls_x   = EW'(left_speed);
  assign rs_x   = EW'(right_speed);
  assign mn_x   = $signed(EW'(cfg.min_speed));
  assign max_x  = $signed(EW'(cfg.max_speed));
  assign step_x = $signed(EW'(step));
  assign ld_x   = DW'(left_drive);
  assign rd_x   = DW'(right_drive);
  assign ld_mag = DW'(ld_x < 0 ? -ld_x : ld_x);
  assign rd_mag = DW'(rd_x < 0 ? -rd_x : rd_x);

  assign ls_seen_n = left_seen  | (MW'({ld_mag, 1'b0}) < MW'(absx(ls_x)));
  assign rs_seen_n = right_seen | (MW'({rd_mag, 1'b0}) < MW'(absx(rs_x)));
  assign ls_slow   = slow_side(ls_x, ls_seen_n, forward_mode, mn_x, step_x);
  assign rs_slow   = slow_side(rs_x, rs_seen_n, forward_mode, mn_x, step_x);
  assign hit = (absx(ls_slow) <= EW'(cfg.min_speed)) &&
               (absx(rs_slow) <= EW'(cfg.min_speed)) &&
               (ld_mag < DW'(cfg.min_speed)) && (rd_mag < DW'(cfg.min_speed));

  always_comb begin
    left_speed_next    = left_speed;
    right_speed_next   = right_speed;
    left_seen_next     = left_seen;
    right_seen_next    = right_seen;
    forward_mode_next  = forward_mode;
    settled_hits_next  = settled_hits;
    elapsed_ms_next    = elapsed_ms;
    run_status_next    = run_status;
    result.left_drive  = '0;
    result.right_drive = '0;
    unique case (ctl.kind)
      lalign_pkg::KIND_START: begin
        forward_mode_next = ctl.direction;
        left_speed_next   = SPEED_BITS'(ctl.direction ? max_x : -max_x);
        right_speed_next  = SPEED_BITS'(ctl.direction ? max_x : -max_x);
        left_seen_next    = 1'b0;
        right_seen_next   = 1'b0;
        settled_hits_next = '0;
        elapsed_ms_next   = '0;
        run_status_next   = (cfg.precision_count == '0) ? lalign_pkg::ST_DONE :
                                                          lalign_pkg::ST_RUN;
      end
      lalign_pkg::KIND_SAMPLE: begin
        if (run_status == lalign_pkg::ST_RUN) begin
          left_seen_next    = ls_seen_n;
          right_seen_next   = rs_seen_n;
          left_speed_next   = SPEED_BITS'(ls_slow);
          right_speed_next  = SPEED_BITS'(rs_slow);
          if (hit && settled_hits != lalign_pkg::HIT_MAX) begin
            settled_hits_next = settled_hits + 1'b1;
          end
          // timeout wins over settling on the same sample
          if (!ls_seen_n && !rs_seen_n && elapsed_ms > cfg.timeout_ms) begin
            run_status_next = lalign_pkg::ST_FAIL;
          end else if (settled_hits_next >= cfg.precision_count) begin
            run_status_next = lalign_pkg::ST_DONE;
          end else begin
            result.left_drive  = left_drive;
            result.right_drive = right_drive;
          end
        end
      end
      lalign_pkg::KIND_TICK: begin
        if (run_status == lalign_pkg::ST_RUN && elapsed_ms != lalign_pkg::ELAPSED_MAX) begin
          elapsed_ms_next = elapsed_ms + 1'b1;
        end
      end
      default: ;
    endcase
    result.status = run_status_next;
  end

  always_ff @(posedge clk) begin
    step <= lalign_pkg::STEP_W'((32'(cfg.max_speed) * lalign_pkg::STEP_RECIP)
                                >> lalign_pkg::STEP_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_speed   <= '0;
      right_speed  <= '0;
      left_seen    <= 1'b0;
      right_seen   <= 1'b0;
      forward_mode <= 1'b0;
      settled_hits <= '0;
      elapsed_ms   <= '0;
      run_status   <= lalign_pkg::ST_IDLE;
    end else if (ctl.apply) begin
      left_speed   <= left_speed_next;
      right_speed  <= right_speed_next;
      left_seen    <= left_seen_next;
      right_seen   <= right_seen_next;
      forward_mode <= forward_mode_next;
      settled_hits <= settled_hits_next;
      elapsed_ms   <= elapsed_ms_next;
      run_status   <= run_status_next;
    end
  end

endmodule

// ===== rtl/lalign_checker.sv =====
module lalign_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [lalign_pkg::M_DATA_W-1:0] m_tdata
);

  localparam int DW = lalign_pkg::DRIVE_W;

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid straight after reset");

  // Drives are zero unless the run is still active
  a_zero_drive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2*DW+1:2*DW] != lalign_pkg::ST_RUN) |-> (m_tdata[2*DW-1:0] == '0))
    else $error("non-zero drive outside an active run");

  // One beat in flight: acceptance closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second beat taken while one is in flight");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind line_alignment_drive_controller lalign_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== bench/tb_line_alignment_drive_controller.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the line alignment drive controller. A behavioural
// model of the two-sided alignment (speed loading, linear drive mapping,
// slowing near the line, settle counting and the no-line timeout) runs on
// every accepted input beat and queues the result the block must return.
// A checker compares each returned beat with the oldest queued result.
module tb_line_alignment_drive_controller;
  import lalign_pkg::*;

  localparam int S_DATA_W      = ((1 + 2*READING_BITS_DEF + 7) / 8) * 8;
  localparam int WATCH_LIMIT   = 4000;  // cycles with no beat anywhere
  localparam int SETTLE_CYCLES = 40;    // quiet wait once every owed result is back
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [S_DATA_W-1:0]    s_tdata;   // direction, left_reading, right_reading (bit 0 up)
  logic [1:0]             s_tuser;   // kind
  logic                   m_tvalid;
  logic                   m_tready;
  logic [M_DATA_W-1:0]    m_tdata;   // left_drive, right_drive, status (bit 0 up)
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Mirror of the block's settings and alignment state, updated on each
  // accepted beat or register write
  cfg_t                             shadow_cfg;
  logic signed [SPEED_BITS_DEF-1:0] left_speed;
  logic signed [SPEED_BITS_DEF-1:0] right_speed;
  bit                               left_seen;
  bit                               right_seen;
  bit                               forward_run;
  logic [CFG_COUNT_W-1:0]           settled_hits;
  logic [CFG_TIME_W-1:0]            elapsed_ms;
  status_t                          run_status;

  result_t pending_results[$];  // drive results owed by the block, oldest first
  int      errors;
  bit      gaps_on;             // random idling on both sides
  int      rx_hold;             // request for a long receiver hold-off
  int      idle_cycles;

  line_alignment_drive_controller u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------
  // Alignment model
  // ---------------------------------------------------------------------

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Map a reading linearly from +speed (full drive reading) to -speed
  // (reverse drive reading); division truncates toward zero, then clip
  // to the 16 bit drive range. Equal bounds give no drive at all.
  function automatic int side_drive(logic [CFG_READ_W-1:0] reading, int speed);
    longint lo, hi, rd, den, v;
    lo  = shadow_cfg.full_drive;
    hi  = shadow_cfg.reverse_drive;
    rd  = reading;
    den = hi - lo;
    if (den == 0) return 0;
    v = (rd - lo) * (-2 * longint'(speed)) / den + speed;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return int'(v);
  endfunction

  // Shed a hundredth of max_speed per sample while the side sees the line,
  // then hold the magnitude at min_speed or above (this also raises a side
  // whose min_speed is above max_speed)
  function automatic int slowed_speed(int speed, bit seen);
    int mn, stp;
    mn  = shadow_cfg.min_speed;
    stp = shadow_cfg.max_speed / 100;
    if (forward_run) begin
      if (seen && speed > mn) speed -= stp;
      if (speed < mn) speed = mn;
    end else begin
      if (seen && speed < -mn) speed += stp;
      if (speed > -mn) speed = -mn;
    end
    return speed;
  endfunction

  function automatic result_t predict_beat(kind_t k, bit dir,
                                           logic [CFG_READ_W-1:0] lr,
                                           logic [CFG_READ_W-1:0] rr);
    result_t res;
    int      ld, rd, ls, rs, mn;
    ld = 0;
    rd = 0;
    mn = shadow_cfg.min_speed;
    case (k)
      KIND_START: begin
        // start (or restart) a run
        forward_run  = dir;
        ls           = shadow_cfg.max_speed;
        left_speed   = SPEED_BITS_DEF'(forward_run ? ls : -ls);
        right_speed  = left_speed;
        left_seen    = 1'b0;
        right_seen   = 1'b0;
        settled_hits = '0;
        elapsed_ms   = '0;
        run_status   = (shadow_cfg.precision_count == 0) ? ST_DONE : ST_RUN;
      end
      KIND_SAMPLE: begin
        if (run_status == ST_RUN) begin
          ls = left_speed;
          rs = right_speed;
          ld = side_drive(lr, ls);
          rd = side_drive(rr, rs);
          if (2 * mag(ld) < mag(ls)) left_seen = 1'b1;
          if (2 * mag(rd) < mag(rs)) right_seen = 1'b1;
          ls = slowed_speed(ls, left_seen);
          rs = slowed_speed(rs, right_seen);
          left_speed  = SPEED_BITS_DEF'(ls);
          right_speed = SPEED_BITS_DEF'(rs);
          if (mag(ls) <= mn && mag(rs) <= mn && mag(rd) < mn && mag(ld) < mn &&
              settled_hits < HIT_MAX)
            settled_hits++;
          // a timeout wins over a settle on the same sample
          if (!left_seen && !right_seen && elapsed_ms > shadow_cfg.timeout_ms) begin
            run_status = ST_FAIL;
            ld = 0;
            rd = 0;
          end else if (settled_hits >= shadow_cfg.precision_count) begin
            run_status = ST_DONE;
            ld = 0;
            rd = 0;
          end
        end
      end
      KIND_TICK: begin
        if (run_status == ST_RUN && elapsed_ms != ELAPSED_MAX) elapsed_ms++;
      end
      default: ;
    endcase
    res.left_drive  = ld[DRIVE_W-1:0];
    res.right_drive = rd[DRIVE_W-1:0];
    res.status      = run_status;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CFG_READ_W-1:0] clamp_reading(int v);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return v[CFG_READ_W-1:0];
  endfunction

  // Offer one beat and hold it until taken; queue its result on acceptance.
  // Valid stays high into the next beat when no gap is drawn.
  task automatic send_beat(kind_t k, bit dir, logic [CFG_READ_W-1:0] lr,
                           logic [CFG_READ_W-1:0] rr);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= S_DATA_W'({rr, lr, dir});
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_beat(k, dir, lr, rr));
  endtask

  task automatic start_run(bit dir);
    send_beat(KIND_START, dir, CFG_READ_W'($urandom_range(0, 4095)),
              CFG_READ_W'($urandom_range(0, 4095)));
  endtask

  task automatic send_sample(int lr, int rr);
    send_beat(KIND_SAMPLE, 1'($urandom_range(0, 1)), clamp_reading(lr), clamp_reading(rr));
  endtask

  task automatic tick();
    send_beat(KIND_TICK, 1'($urandom_range(0, 1)), CFG_READ_W'($urandom_range(0, 4095)),
              CFG_READ_W'($urandom_range(0, 4095)));
  endtask

  task automatic stray_beat();
    send_beat(KIND_NONE, 1'($urandom_range(0, 1)), CFG_READ_W'($urandom_range(0, 4095)),
              CFG_READ_W'($urandom_range(0, 4095)));
  endtask

  // Sample around the midpoint of the reading bounds; the spread narrows as
  // the run goes on, so the sides see the line, slow down and settle
  task automatic send_near_line(int step);
    int mid, span, w, lv, rv;
    mid  = (int'(shadow_cfg.full_drive) + int'(shadow_cfg.reverse_drive)) / 2;
    span = mag(int'(shadow_cfg.reverse_drive) - int'(shadow_cfg.full_drive)) / 2 + 1;
    w    = span >> ((step < 12) ? step : 12);
    lv   = $urandom_range(0, 2 * w);
    rv   = $urandom_range(0, 2 * w);
    send_sample(mid - w + lv, mid - w + rv);
  endtask

  // Drop valid and hold the sender until every owed result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FULL_DRIVE:    shadow_cfg.full_drive      = val[CFG_READ_W-1:0];
      CFG_REVERSE_DRIVE: shadow_cfg.reverse_drive   = val[CFG_READ_W-1:0];
      CFG_MIN_SPEED:     shadow_cfg.min_speed       = val[CFG_SPEED_W-1:0];
      CFG_MAX_SPEED:     shadow_cfg.max_speed       = val[CFG_SPEED_W-1:0];
      CFG_PRECISION:     shadow_cfg.precision_count = val[CFG_COUNT_W-1:0];
      CFG_TIMEOUT:       shadow_cfg.timeout_ms      = val[CFG_TIME_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_settings(int full, int rev, int mn, int mx, int prec, int tmo);
    write_reg(CFG_FULL_DRIVE, 16'(full));
    write_reg(CFG_REVERSE_DRIVE, 16'(rev));
    write_reg(CFG_MIN_SPEED, 16'(mn));
    write_reg(CFG_MAX_SPEED, 16'(mx));
    write_reg(CFG_PRECISION, 16'(prec));
    write_reg(CFG_TIMEOUT, 16'(tmo));
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset settings: beats while idle, unknown kind, restart while running,
  // reading extremes
  task automatic test_idle_and_defaults();
    send_sample(0, 4095);          // not running: no drive, status idle
    tick();                        // not running: time does not advance
    stray_beat();
    start_run(1'b1);
    send_sample(4095, 0);
    send_sample(2050, 2050);
    stray_beat();
    start_run(1'b0);               // restart mid-run, backward
    send_sample(100, 4000);
    drain();
  endtask

  // Register extremes with a one-count span: drives clip both ways;
  // then equal reading bounds give no drive
  task automatic test_saturation_and_equal_bounds();
    write_settings(4095, 4094, 0, 2047, 255, 65535);
    start_run(1'b1);
    send_sample(0, 4095);
    start_run(1'b0);
    send_sample(0, 4095);
    drain();
    write_reg(CFG_FULL_DRIVE, 16'd2000);
    write_reg(CFG_REVERSE_DRIVE, 16'd2000);
    start_run(1'b1);
    send_sample(0, 4095);
    drain();
  endtask

  // A zero settle count finishes the run on its start beat
  task automatic test_zero_precision();
    write_settings(0, 4095, 100, 500, 0, 10);
    start_run(1'b1);
    send_sample(2047, 2047);
    tick();
    drain();
  endtask

  // min_speed above max_speed: the first sample lifts the speed to min_speed
  // and settles at once. With a tick first, the same sample also times out,
  // and the failure wins.
  task automatic test_min_above_max();
    write_settings(0, 4095, 200, 100, 1, 0);
    start_run(1'b1);
    tick();
    send_sample(0, 0);
    start_run(1'b1);
    send_sample(0, 0);
    start_run(1'b0);
    send_sample(4095, 4095);
    drain();
  endtask

  // Far from the line with time running out: the run fails, and ticks
  // after that no longer count
  task automatic test_timeout();
    write_settings(100, 4000, 150, 1500, 25, 2);
    start_run(1'b1);
    repeat (3) tick();
    send_sample(100, 100);
    tick();
    send_sample(2050, 2050);
    drain();
  endtask

  // Hold the receiver off for a long stretch while beats keep coming, so the
  // block fills and stalls its input; write the reset values back on the way
  task automatic test_receiver_holdoff();
    write_settings(RST_FULL_DRIVE, RST_REVERSE_DRIVE, RST_MIN_SPEED, RST_MAX_SPEED,
                   RST_PRECISION, RST_TIMEOUT);
    gaps_on = 1'b0;
    rx_hold = HOLD_CYCLES;
    start_run(1'b1);
    repeat (12) send_near_line($urandom_range(0, 6));
    drain();
  endtask

  // Random settings per phase; each phase runs a few alignment runs made
  // mostly of samples closing in on the line, with ticks, noise and
  // unknown beats mixed in
  task automatic test_random_runs();
    int live, n, r, step, full, rev, mn, mx, prec, tmo;
    live = 0;
    while (live < 140) begin
      drain();
      mx = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 2047 : 0)
                                       : $urandom_range(100, 2047);
      mn = (mx * $urandom_range(70, 110)) / 100;
      if (mn > 2047) mn = 2047;
      if ($urandom_range(0, 9) == 0) mn = $urandom_range(0, 2047);
      full = $urandom_range(0, 800);
      rev  = $urandom_range(3200, 4095);
      r    = $urandom_range(0, 19);
      if (r == 0) begin
        full = rev;
        rev  = $urandom_range(0, 800);
      end else if (r == 1) begin
        rev = full;
      end else if (r == 2) begin
        full = 0;
        rev  = 4095;
      end else if (r == 3) begin
        full = 4095;
        rev  = 0;
      end
      r    = $urandom_range(0, 19);
      prec = (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(1, 6);
      tmo  = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(0, 30);
      write_settings(full, rev, mn, mx, prec, tmo);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 4)) begin
        start_run(1'($urandom_range(0, 1)));
        live++;
        n    = $urandom_range(8, 60);
        step = 0;
        while (run_status == ST_RUN && n > 0) begin
          r = $urandom_range(0, 99);
          if (r < 15) begin
            tick();
          end else if (r < 18) begin
            stray_beat();
          end else if (r < 28) begin
            send_sample($urandom_range(0, 4095), $urandom_range(0, 4095));
          end else begin
            send_near_line(step);
            step++;
          end
          if (r < 15 || r >= 18) live++;
          n--;
        end
        // now and then poke the run once its loop ends, finished or not
        if ($urandom_range(0, 3) == 0)
          send_sample($urandom_range(0, 4095), $urandom_range(0, 4095));
      end
    end
    drain();
  endtask

  // Long count: the settle count climbs to its 8 bit ceiling before the
  // run finishes
  task automatic test_counter_limits();
    int n;
    gaps_on = 1'b0;
    write_settings(0, 4095, 2047, 0, 255, 65534);
    start_run(1'b1);
    n = 0;
    while (run_status == ST_RUN && n < 300) begin
      send_sample(2047, 2047);
      n++;
    end
    drain();
  endtask

  // ---------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------

  // Receiver ready: random gaps, or a long counted hold-off on request
  initial begin : rx_ready
    int g;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
        m_tready <= 1'b1;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          m_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each returned beat with the oldest owed result
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing owed, expected none, actual %h",
                 $time, m_tdata);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[15:0] !== want.left_drive) begin
          errors++;
          $display("%0t: left_drive expected %0d actual %0d",
                   $time, want.left_drive, $signed(m_tdata[15:0]));
        end
        if (m_tdata[31:16] !== want.right_drive) begin
          errors++;
          $display("%0t: right_drive expected %0d actual %0d",
                   $time, want.right_drive, $signed(m_tdata[31:16]));
        end
        if (m_tdata[33:32] !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, m_tdata[33:32]);
        end
      end
    end
  end

  // End the run if no beat moves on any channel for too long
  always @(posedge clk) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("tb_line_alignment_drive_controller failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    errors      = 0;
    gaps_on     = 1'b1;
    rx_hold     = 0;
    idle_cycles = 0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= KIND_START;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_FULL_DRIVE;
    cfg_data  <= '0;

    // mirror the reset state
    shadow_cfg.full_drive      = RST_FULL_DRIVE;
    shadow_cfg.reverse_drive   = RST_REVERSE_DRIVE;
    shadow_cfg.min_speed       = RST_MIN_SPEED;
    shadow_cfg.max_speed       = RST_MAX_SPEED;
    shadow_cfg.precision_count = RST_PRECISION;
    shadow_cfg.timeout_ms      = RST_TIMEOUT;
    left_speed   = '0;
    right_speed  = '0;
    left_seen    = 1'b0;
    right_seen   = 1'b0;
    forward_run  = 1'b0;
    settled_hits = '0;
    elapsed_ms   = '0;
    run_status   = ST_IDLE;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_and_defaults();
    test_saturation_and_equal_bounds();
    test_zero_precision();
    test_min_above_max();
    test_timeout();
    test_receiver_holdoff();
    test_random_runs();
    test_counter_limits();
    drain();

    if (errors == 0) begin
      $display("tb_line_alignment_drive_controller passed");
    end else begin
      $display("tb_line_alignment_drive_controller failed");
    end
    $finish;
  end

endmodule
